@@ hdl/plid_pkg.sv @@
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and constants for the positional list insert/delete block.
// ----------------------------------------------------------------------------
package plid_pkg;

  localparam int DEPTH     = 64;
  localparam int ELEM_BITS = 32;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam int MODE_W = 1;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 7;

  localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam int IN_DATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = ST_W + VAL_W + LEN_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

  localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic    load;
    logic    clr_rem;
    logic    st_we;
    status_e st_code;
    logic    rd_first;
    logic    rd_loop;
    logic    cap_rem;
    logic    cur_init_ins;
    logic    cur_init_del;
    logic    cur_step;
    logic    wr_shift;
    logic    wr_value;
    logic    cnt_inc;
    logic    cnt_dec;
  } dp_cmd_t;

  typedef struct packed {
    logic is_del;
    logic bad_pos;
    logic full;
    logic more;
  } dp_stat_t;

endpackage

@@ hdl/plid_dpath.sv @@
// ----------------------------------------------------------------------------
// plid_dpath
// List storage, length, move cursor and result registers.
// ----------------------------------------------------------------------------
module plid_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  plid_pkg::dp_cmd_t            cmd_i,
  output plid_pkg::dp_stat_t           stat_o,
  input  logic [plid_pkg::MODE_W-1:0]  req_mode_i,
  input  logic [plid_pkg::POS_W-1:0]   req_pos_i,
  input  logic [plid_pkg::VAL_W-1:0]   req_val_i,
  output logic [plid_pkg::ST_W-1:0]    status_o,
  output logic [plid_pkg::VAL_W-1:0]   removed_o,
  output logic [plid_pkg::LEN_W-1:0]   length_o
);

  logic [plid_pkg::ELEM_BITS-1:0] mem_q [plid_pkg::DEPTH];

  logic [plid_pkg::MODE_W-1:0]    mode_q;
  logic [plid_pkg::POS_W-1:0]     pos_q;
  logic [plid_pkg::ELEM_BITS-1:0] val_q;
  logic [plid_pkg::ELEM_BITS-1:0] rdata_q;
  logic [plid_pkg::ELEM_BITS-1:0] rem_q;
  plid_pkg::status_e              status_q;
  logic [plid_pkg::CW-1:0]        cur_q, cur_d;
  logic [plid_pkg::CW-1:0]        count_q, count_d;

  logic                           is_del;
  logic [plid_pkg::POS_W-1:0]     idx_p;
  logic [plid_pkg::CW-1:0]        idx;
  logic [plid_pkg::CMP_W-1:0]     pos_ext;
  logic [plid_pkg::CMP_W-1:0]     cnt_ext;
  logic [plid_pkg::CW-1:0]        cur_dn;
  logic [plid_pkg::CW-1:0]        cur_up;
  logic [plid_pkg::CW-1:0]        rd_addr_w;
  logic [plid_pkg::CW-1:0]        wr_addr_w;
  logic                           rd_en;
  logic                           wr_en;
  logic [plid_pkg::ELEM_BITS-1:0] wr_data;

  function automatic logic [plid_pkg::POS_W-1:0] req_pos_dec(
    input logic [plid_pkg::POS_W-1:0] p
  );
    return p - plid_pkg::POS_W'(1);
  endfunction

  assign is_del  = (mode_q == plid_pkg::MODE_DELETE);
  assign idx_p   = req_pos_dec(pos_q);
  assign idx     = plid_pkg::CW'(idx_p);
  assign pos_ext = plid_pkg::CMP_W'(pos_q);
  assign cnt_ext = plid_pkg::CMP_W'(count_q);
  assign cur_dn  = cur_q - plid_pkg::CW'(1);
  assign cur_up  = cur_q + plid_pkg::CW'(1);

  // position checks
  always_comb begin
    stat_o.is_del  = is_del;
    stat_o.full    = (count_q == plid_pkg::CW'(plid_pkg::DEPTH));
    stat_o.bad_pos = (pos_q == '0) ||
                     (is_del ? (pos_ext > cnt_ext)
                             : (pos_ext > cnt_ext + plid_pkg::CMP_W'(1)));
    stat_o.more    = is_del ? (cur_q < count_q) : (cur_q > idx);
  end

  assign rd_en     = cmd_i.rd_first | cmd_i.rd_loop;
  assign rd_addr_w = cmd_i.rd_first ? idx : (is_del ? cur_q : cur_dn);
  assign wr_en     = cmd_i.wr_shift | cmd_i.wr_value;
  assign wr_addr_w = cmd_i.wr_value ? idx : (is_del ? cur_dn : cur_q);
  assign wr_data   = cmd_i.wr_value ? val_q : rdata_q;

  // list storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr_w[plid_pkg::AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr_w[plid_pkg::AW-1:0]];
    end
  end

  always_comb begin
    cur_d = cur_q;
    if (cmd_i.cur_init_ins) begin
      cur_d = count_q;
    end else if (cmd_i.cur_init_del) begin
      cur_d = idx + plid_pkg::CW'(1);
    end else if (cmd_i.cur_step) begin
      cur_d = is_del ? cur_up : cur_dn;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + plid_pkg::CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - plid_pkg::CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // request and result registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.load) begin
      mode_q <= req_mode_i;
      pos_q  <= req_pos_i;
      val_q  <= plid_pkg::ELEM_BITS'(req_val_i);
    end
    if (cmd_i.clr_rem) begin
      rem_q <= '0;
    end else if (cmd_i.cap_rem) begin
      rem_q <= rdata_q;
    end
    if (cmd_i.st_we) begin
      status_q <= cmd_i.st_code;
    end
  end

  assign status_o  = status_q;
  assign removed_o = plid_pkg::VAL_W'(rem_q);
  assign length_o  = plid_pkg::LEN_W'(count_q);

endmodule

@@ hdl/plid_ctrl.sv @@
// ----------------------------------------------------------------------------
// plid_ctrl
// Sequencer for checks, entry moves and result handshake.
// ----------------------------------------------------------------------------
module plid_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output plid_pkg::dp_cmd_t  cmd_o,
  input  plid_pkg::dp_stat_t stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RMV,
    S_RD,
    S_WR,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o         = '0;
    cmd_o.st_code = plid_pkg::ST_OK;
    state_d       = state_q;
    in_ready_d    = in_ready_q;
    out_valid_d   = out_valid_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load = 1'b1;
          in_ready_d = 1'b0;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.clr_rem = 1'b1;
        cmd_o.st_we   = 1'b1;
        if (stat_i.bad_pos) begin
          cmd_o.st_code = plid_pkg::ST_RANGE;
          out_valid_d   = 1'b1;
          state_d       = S_OUT;
        end else if (!stat_i.is_del && stat_i.full) begin
          cmd_o.st_code = plid_pkg::ST_FULL;
          out_valid_d   = 1'b1;
          state_d       = S_OUT;
        end else if (stat_i.is_del) begin
          cmd_o.rd_first = 1'b1;
          state_d        = S_RMV;
        end else begin
          cmd_o.cur_init_ins = 1'b1;
          state_d            = S_RD;
        end
      end
      S_RMV: begin
        cmd_o.cap_rem      = 1'b1;
        cmd_o.cur_init_del = 1'b1;
        state_d            = S_RD;
      end
      S_RD: begin
        if (stat_i.more) begin
          cmd_o.rd_loop = 1'b1;
          state_d       = S_WR;
        end else begin
          if (stat_i.is_del) begin
            cmd_o.cnt_dec = 1'b1;
          end else begin
            cmd_o.wr_value = 1'b1;
            cmd_o.cnt_inc  = 1'b1;
          end
          out_valid_d = 1'b1;
          state_d     = S_OUT;
        end
      end
      S_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.cur_step = 1'b1;
        state_d        = S_RD;
      end
      S_OUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          in_ready_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/positional_list_insert_delete.sv @@
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of up to DEPTH entries with insert and delete at a 1-based
// position; one status result out for every request in.
// ----------------------------------------------------------------------------
// Entries live in a single-port-write, single-port-read memory, and every
// entry that has to move takes one registered read and one write. An insert
// at position p moves each entry from p onward up one, then writes the value;
// a delete captures the entry at p, then moves each later entry down one. A
// rejected request (bad position or full list) is answered after the check.
// A new request is accepted in the cycle after the result is taken. After
// reset the list is empty and the block is ready at once.
module positional_list_insert_delete (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // position [6:0], value [38:7], zero fill above
  input  logic [plid_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // mode [0]
  input  logic [plid_pkg::MODE_W-1:0]       s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // status [1:0], removed_value [33:2], list_length [40:34], zero fill above
  output logic [plid_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  plid_pkg::dp_cmd_t           cmd;
  plid_pkg::dp_stat_t          stat;
  logic [plid_pkg::ST_W-1:0]   status;
  logic [plid_pkg::VAL_W-1:0]  removed;
  logic [plid_pkg::LEN_W-1:0]  length;

  plid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  plid_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .req_mode_i (s_axis_tuser_i),
    .req_pos_i  (s_axis_tdata_i[plid_pkg::POS_W-1:0]),
    .req_val_i  (s_axis_tdata_i[plid_pkg::POS_W+plid_pkg::VAL_W-1:plid_pkg::POS_W]),
    .status_o   (status),
    .removed_o  (removed),
    .length_o   (length)
  );

  assign m_axis_tdata_o = {{plid_pkg::OUT_PAD_W{1'b0}}, length, removed, status};

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for positional_list_insert_delete: a directed table of
// inserts and deletes, a fill to a full list, then random phases that grow,
// shrink and churn the list. A shadow list in the bench predicts the result of
// each request but typed directed rows, which carry their own; both stream
// sides idle at random and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

  localparam int ITEMS        = 1050;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int N_DIRECTED   = 15;

  typedef struct packed {
    plid_pkg::status_e          status;
    logic [plid_pkg::VAL_W-1:0] removed;
    logic [plid_pkg::LEN_W-1:0] len;
  } list_result_t;

  typedef struct packed {
    logic [plid_pkg::MODE_W-1:0] mode;
    logic [plid_pkg::POS_W-1:0]  pos;
    logic [plid_pkg::VAL_W-1:0]  val;
    logic                        typed;
    list_result_t                want;
  } directed_row_t;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_NOISE} phase_e;

  localparam directed_row_t DIRECTED [0:N_DIRECTED-1] = '{
    '{plid_pkg::MODE_DELETE, 7'd1,   32'h0000_0000, 1'b1, '{plid_pkg::ST_RANGE, 32'h0, 7'd0}},
    '{plid_pkg::MODE_INSERT, 7'd0,   32'h1234_5678, 1'b1, '{plid_pkg::ST_RANGE, 32'h0, 7'd0}},
    '{plid_pkg::MODE_INSERT, 7'd2,   32'h1234_5678, 1'b1, '{plid_pkg::ST_RANGE, 32'h0, 7'd0}},
    '{plid_pkg::MODE_INSERT, 7'd1,   32'hFFFF_FFFF, 1'b1, '{plid_pkg::ST_OK,    32'h0, 7'd1}},
    '{plid_pkg::MODE_INSERT, 7'd1,   32'h0000_0000, 1'b1, '{plid_pkg::ST_OK,    32'h0, 7'd2}},
    '{plid_pkg::MODE_INSERT, 7'd3,   32'hA5A5_A5A5, 1'b0, '{plid_pkg::ST_OK,    32'h0, 7'd0}},
    '{plid_pkg::MODE_INSERT, 7'd2,   32'h5A5A_5A5A, 1'b0, '{plid_pkg::ST_OK,    32'h0, 7'd0}},
    '{plid_pkg::MODE_INSERT, 7'd127, 32'hFFFF_FFFF, 1'b1, '{plid_pkg::ST_RANGE, 32'h0, 7'd4}},
    '{plid_pkg::MODE_DELETE, 7'd0,   32'h0000_0000, 1'b1, '{plid_pkg::ST_RANGE, 32'h0, 7'd4}},
    '{plid_pkg::MODE_DELETE, 7'd5,   32'h0000_0000, 1'b1, '{plid_pkg::ST_RANGE, 32'h0, 7'd4}},
    '{plid_pkg::MODE_DELETE, 7'd4,   32'h0000_0000, 1'b0, '{plid_pkg::ST_OK,    32'h0, 7'd0}},
    '{plid_pkg::MODE_DELETE, 7'd1,   32'h0000_0000, 1'b0, '{plid_pkg::ST_OK,    32'h0, 7'd0}},
    '{plid_pkg::MODE_DELETE, 7'd1,   32'hDEAD_BEEF, 1'b0, '{plid_pkg::ST_OK,    32'h0, 7'd0}},
    '{plid_pkg::MODE_DELETE, 7'd1,   32'h0000_0000, 1'b0, '{plid_pkg::ST_OK,    32'h0, 7'd0}},
    '{plid_pkg::MODE_DELETE, 7'd1,   32'h0000_0000, 1'b1, '{plid_pkg::ST_RANGE, 32'h0, 7'd0}}
  };

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [plid_pkg::IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [plid_pkg::MODE_W-1:0]     s_axis_tuser_i  = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [plid_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;

  logic [plid_pkg::VAL_W-1:0] shadow_list [$];
  list_result_t               pending_results [$];
  int                         mismatch_count = 0;
  int                         requests_sent  = 0;
  int                         results_seen   = 0;
  int                         cycle_count    = 0;

  positional_list_insert_delete dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic list_result_t apply_request(
    input logic [plid_pkg::MODE_W-1:0] mode,
    input logic [plid_pkg::POS_W-1:0]  pos,
    input logic [plid_pkg::VAL_W-1:0]  val
  );
    list_result_t r;
    int           n;
    int           p;
    n         = shadow_list.size();
    p         = pos;
    r.status  = plid_pkg::ST_OK;
    r.removed = '0;
    if (mode == plid_pkg::MODE_INSERT) begin
      if (p < 1 || p > n + 1) begin
        r.status = plid_pkg::ST_RANGE;
      end else if (n >= plid_pkg::DEPTH) begin
        r.status = plid_pkg::ST_FULL;
      end else begin
        shadow_list.insert(p - 1, val);
      end
    end else begin
      if (p < 1 || p > n) begin
        r.status = plid_pkg::ST_RANGE;
      end else begin
        r.removed = shadow_list[p - 1];
        shadow_list.delete(p - 1);
      end
    end
    r.len = plid_pkg::LEN_W'(shadow_list.size());
    return r;
  endfunction

  function automatic logic [plid_pkg::VAL_W-1:0] pick_value();
    logic [plid_pkg::VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_request(input logic [plid_pkg::MODE_W-1:0] mode,
                              input logic [plid_pkg::POS_W-1:0] pos,
                              input logic [plid_pkg::VAL_W-1:0] val,
                              input logic typed,
                              input list_result_t want,
                              input bit no_gap);
    int           gap;
    list_result_t predicted;
    gap = no_gap ? 0 : (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16));
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= {{(plid_pkg::IN_DATA_W-plid_pkg::POS_W-plid_pkg::VAL_W){1'b0}},
                        val, pos};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = apply_request(mode, pos, val);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  // result side
  initial begin
    int                         stall;
    bit                         rx_fast;
    list_result_t               want;
    logic [plid_pkg::ST_W-1:0]  got_status;
    logic [plid_pkg::VAL_W-1:0] got_removed;
    logic [plid_pkg::LEN_W-1:0] got_len;
    rx_fast = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (results_seen % 32 == 0) rx_fast = ($urandom_range(0, 3) == 0);
      if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
      else stall = rx_fast ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      got_status  = m_axis_tdata_o[plid_pkg::ST_W-1:0];
      got_removed = m_axis_tdata_o[plid_pkg::ST_W+plid_pkg::VAL_W-1:plid_pkg::ST_W];
      got_len     = m_axis_tdata_o[plid_pkg::ST_W+plid_pkg::VAL_W+plid_pkg::LEN_W-1:
                                   plid_pkg::ST_W+plid_pkg::VAL_W];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, got_status);
          mismatch_count++;
        end
        if (got_removed !== want.removed) begin
          $display("%0t: removed value mismatch, expected %h, actual %h",
                   $time, want.removed, got_removed);
          mismatch_count++;
        end
        if (got_len !== want.len) begin
          $display("%0t: list length mismatch, expected %0d, actual %0d",
                   $time, want.len, got_len);
          mismatch_count++;
        end
      end
      results_seen++;
    end
  end

  // request side
  initial begin
    phase_e                     phase;
    int                         phase_len;
    int                         n;
    bit                         burst;
    bit                         ins;
    logic [plid_pkg::POS_W-1:0] pos;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_request(DIRECTED[i].mode, DIRECTED[i].pos, DIRECTED[i].val,
                   DIRECTED[i].typed, DIRECTED[i].want, 1'b0);
    end

    // fill to capacity, then poke the full list
    while (shadow_list.size() < plid_pkg::DEPTH) begin
      send_request(plid_pkg::MODE_INSERT,
                   plid_pkg::POS_W'($urandom_range(1, shadow_list.size() + 1)),
                   pick_value(), 1'b0, '0, 1'b0);
    end
    send_request(plid_pkg::MODE_INSERT, plid_pkg::POS_W'(plid_pkg::DEPTH + 1),
                 pick_value(), 1'b0, '0, 1'b0);
    send_request(plid_pkg::MODE_INSERT, 7'd1, pick_value(), 1'b0, '0, 1'b0);
    send_request(plid_pkg::MODE_INSERT, plid_pkg::POS_W'(plid_pkg::DEPTH + 2),
                 pick_value(), 1'b0, '0, 1'b0);
    send_request(plid_pkg::MODE_INSERT, 7'd0, pick_value(), 1'b0, '0, 1'b0);
    send_request(plid_pkg::MODE_DELETE, plid_pkg::POS_W'(plid_pkg::DEPTH + 1),
                 pick_value(), 1'b0, '0, 1'b0);
    send_request(plid_pkg::MODE_DELETE, plid_pkg::POS_W'(plid_pkg::DEPTH),
                 pick_value(), 1'b0, '0, 1'b0);
    send_request(plid_pkg::MODE_INSERT, plid_pkg::POS_W'(plid_pkg::DEPTH),
                 pick_value(), 1'b0, '0, 1'b0);
    send_request(plid_pkg::MODE_DELETE, 7'd1, pick_value(), 1'b0, '0, 1'b0);

    while (requests_sent < ITEMS) begin
      phase     = phase_e'($urandom_range(0, 3));
      phase_len = $urandom_range(20, 80);
      burst     = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len && requests_sent < ITEMS; i++) begin
        n = shadow_list.size();
        case (phase)
          PH_GROW:   ins = ($urandom_range(0, 99) < 85);
          PH_SHRINK: ins = ($urandom_range(0, 99) < 15);
          default:   ins = ($urandom_range(0, 99) < 50);
        endcase
        if (phase == PH_NOISE || $urandom_range(0, 9) == 0) begin
          pos = plid_pkg::POS_W'($urandom_range(0, 127));
        end else if (ins) begin
          pos = plid_pkg::POS_W'($urandom_range(1, n + 1));
        end else begin
          pos = (n == 0) ? 7'd1 : plid_pkg::POS_W'($urandom_range(1, n));
        end
        send_request(ins ? plid_pkg::MODE_INSERT : plid_pkg::MODE_DELETE, pos,
                     pick_value(), 1'b0, '0, burst);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/plid_pkg.sv
hdl/plid_dpath.sv
hdl/plid_ctrl.sv
hdl/positional_list_insert_delete.sv
sim/tb.sv
